// ===== src/assert_macros.svh =====
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ricf_pkg.sv =====
// ----------------------------------------------------------------------------
// ricf_pkg
// Shared constants and types of the ROM image checksum fixer.
// ----------------------------------------------------------------------------
package ricf_pkg;

    localparam int IMAGE_BYTES_DEF = 32768;
    localparam int ENTRY_BYTES_DEF = 20;

    localparam int OFFSET_W = 15;
    localparam int HITS_W   = 2;
    localparam int SIG_BYTES = 4;

    localparam logic [23:0] SIG_PMI = 24'h504D49;
    localparam logic [7:0]  SIG_D   = 8'h44;
    localparam logic [7:0]  SIG_SUM = 8'h2A;

    // match count codes
    localparam logic [HITS_W-1:0] HITS_NONE = 2'd0;
    localparam logic [HITS_W-1:0] HITS_ONE  = 2'd1;
    localparam logic [HITS_W-1:0] HITS_MANY = 2'd2;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] data_byte;
    } t_step;

    typedef struct packed {
        logic [HITS_W-1:0]   entry_hits;
        logic [OFFSET_W-1:0] entry_offset;
        logic [7:0]          entry_sum_stored;
        logic [7:0]          entry_sum_calc;
        logic                entry_fix;
        logic [7:0]          image_sum_stored;
        logic [7:0]          image_sum_calc;
        logic                image_fix;
    } t_result;

endpackage

// ===== src/ricf_scan.sv =====
// ----------------------------------------------------------------------------
// ricf_scan
// Running image state: byte position, signature search, entry and image sums.
// Produces the result for the image as it stands after the current beat.
// ----------------------------------------------------------------------------
module ricf_scan
    import ricf_pkg::*;
#(
    parameter int IMAGE_BYTES = IMAGE_BYTES_DEF,
    parameter int ENTRY_BYTES = ENTRY_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_step   i_step,
    output t_result o_result
);

    localparam int PW = $clog2(IMAGE_BYTES + 1);
    localparam logic [PW-1:0] IMG_END   = PW'(IMAGE_BYTES);
    localparam logic [PW-1:0] LAST_POS  = PW'(IMAGE_BYTES - 1);
    localparam logic [PW-1:0] MAX_START = PW'(IMAGE_BYTES - ENTRY_BYTES - 1);
    localparam logic [PW-1:0] CSUM_K    = PW'(ENTRY_BYTES - 1);
    localparam logic [PW-1:0] SIG_LEN   = PW'(SIG_BYTES);
    localparam logic [PW-1:0] SIG_BACK  = PW'(SIG_BYTES - 1);

    logic [PW-1:0]     r_pos, n_pos;
    logic [23:0]       r_recent, n_recent;
    logic [7:0]        r_sum, n_sum;
    logic [HITS_W-1:0] r_hits, n_hits;
    logic [PW-1:0]     r_off, n_off;
    logic [7:0]        r_esum, n_esum;
    logic [7:0]        r_estored, n_estored;
    logic [7:0]        r_final, n_final;

    logic [PW-1:0] k;
    logic [PW-1:0] start;
    logic [7:0]    e_stored, e_calc, img, img_calc;
    logic          single;

    assign k     = r_pos - r_off;
    assign start = r_pos - SIG_BACK;

    always_comb begin
        n_pos     = r_pos;
        n_recent  = r_recent;
        n_sum     = r_sum;
        n_hits    = r_hits;
        n_off     = r_off;
        n_esum    = r_esum;
        n_estored = r_estored;
        n_final   = r_final;
        if (r_pos < IMG_END) begin
            if (r_pos != LAST_POS) begin
                n_sum = r_sum + i_step.data_byte;
            end else begin
                n_final = i_step.data_byte;
            end
            // bytes of the current entry behind the signature
            if (r_hits != HITS_NONE && r_pos >= r_off) begin
                if (k >= SIG_LEN && k < CSUM_K) begin
                    n_esum = r_esum + i_step.data_byte;
                end else if (k == CSUM_K) begin
                    n_estored = i_step.data_byte;
                end
            end
            if (r_pos >= SIG_LEN && r_recent == SIG_PMI && i_step.data_byte == SIG_D
                    && start <= MAX_START) begin
                if (r_hits != HITS_MANY) begin
                    n_hits = r_hits + HITS_ONE;
                end
                n_off     = start;
                n_esum    = SIG_SUM;
                n_estored = 8'd0;
            end
            n_recent = {r_recent[15:0], i_step.data_byte};
            n_pos    = r_pos + PW'(1);
        end
    end

    // result for the image including this beat
    always_comb begin
        single   = (n_hits == HITS_ONE);
        e_stored = (n_hits != HITS_NONE) ? n_estored : 8'd0;
        e_calc   = (n_hits != HITS_NONE) ? (8'd0 - n_esum) : 8'd0;
        img      = single ? (n_sum - e_stored + e_calc) : n_sum;
        img_calc = 8'd0 - img;

        o_result.entry_hits       = n_hits;
        o_result.entry_offset     = (n_hits != HITS_NONE) ? OFFSET_W'(n_off) : '0;
        o_result.entry_sum_stored = e_stored;
        o_result.entry_sum_calc   = e_calc;
        o_result.entry_fix        = single && (e_stored != e_calc);
        o_result.image_sum_stored = n_final;
        o_result.image_sum_calc   = img_calc;
        o_result.image_fix        = (n_final != img_calc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.valid && i_step.last)) begin
            r_pos     <= '0;
            r_recent  <= '0;
            r_sum     <= '0;
            r_hits    <= HITS_NONE;
            r_off     <= '0;
            r_esum    <= '0;
            r_estored <= '0;
            r_final   <= '0;
        end else if (i_step.valid) begin
            r_pos     <= n_pos;
            r_recent  <= n_recent;
            r_sum     <= n_sum;
            r_hits    <= n_hits;
            r_off     <= n_off;
            r_esum    <= n_esum;
            r_estored <= n_estored;
            r_final   <= n_final;
        end
    end

endmodule

// ===== src/rom_image_checksum_fixer_unit.sv =====
// a result is registered as its last byte moves on from the input register
// one byte per cycle unless stalled; input register, scan logic, result register
// a held result stalls the input only while a last byte waits in the input register
// reset (i_rst_n low, synchronous) empties both registers and clears the image
// state; after each result the state starts a new image at position 0
// ----------------------------------------------------------------------------
// rom_image_checksum_fixer_unit
// Checks and computes the option ROM image checksum and the PMID entry checksum.
// ----------------------------------------------------------------------------
module rom_image_checksum_fixer_unit
    import ricf_pkg::*;
#(
    parameter int IMAGE_BYTES = IMAGE_BYTES_DEF,
    parameter int ENTRY_BYTES = ENTRY_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [HITS_W-1:0]   o_entry_hits,
    output logic [OFFSET_W-1:0] o_entry_offset,
    output logic [7:0]          o_entry_sum_stored,
    output logic [7:0]          o_entry_sum_calc,
    output logic                o_entry_fix,
    output logic [7:0]          o_image_sum_stored,
    output logic [7:0]          o_image_sum_calc,
    output logic                o_image_fix
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_result;

    t_step   step;
    t_result scan_result;
    logic    out_free, advance, in_load, out_load;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = r_in_valid && (!r_in_last || out_free);
    assign in_load  = !r_in_valid || advance;
    assign out_load = advance && r_in_last;

    assign step.valid     = advance;
    assign step.last      = r_in_last;
    assign step.data_byte = r_in_byte;

    ricf_scan #(
        .IMAGE_BYTES(IMAGE_BYTES),
        .ENTRY_BYTES(ENTRY_BYTES)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_result(scan_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
        if (out_load) begin
            r_result <= scan_result;
        end
    end

    assign o_in_stall         = !in_load;
    assign o_out_valid        = r_out_valid;
    assign o_entry_hits       = r_result.entry_hits;
    assign o_entry_offset     = r_result.entry_offset;
    assign o_entry_sum_stored = r_result.entry_sum_stored;
    assign o_entry_sum_calc   = r_result.entry_sum_calc;
    assign o_entry_fix        = r_result.entry_fix;
    assign o_image_sum_stored = r_result.image_sum_stored;
    assign o_image_sum_calc   = r_result.image_sum_calc;
    assign o_image_fix        = r_result.image_fix;

endmodule

// ===== src/ricf_checker.sv =====
// ----------------------------------------------------------------------------
// ricf_checker
// Port level checks of the ROM image checksum fixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ricf_checker
    import ricf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [HITS_W-1:0]   o_entry_hits,
    input logic [OFFSET_W-1:0] o_entry_offset,
    input logic [7:0]          o_entry_sum_stored,
    input logic [7:0]          o_entry_sum_calc,
    input logic                o_entry_fix,
    input logic [7:0]          o_image_sum_stored,
    input logic [7:0]          o_image_sum_calc,
    input logic                o_image_fix
);

    // stalled result beat holds
    `ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_image_sum_calc) && $stable(o_entry_offset)
            && $stable(o_entry_hits),
        "result beat changed while stalled")

    // match count saturates at two
    `ASSERT_ALWAYS(a_hits_range, !o_out_valid || o_entry_hits <= HITS_MANY,
        "entry hit count out of range")

    // no match leaves the entry fields clear
    `ASSERT_ALWAYS(a_no_entry, !(o_out_valid && o_entry_hits == HITS_NONE)
        || (o_entry_offset == '0 && o_entry_sum_stored == 8'd0
            && o_entry_sum_calc == 8'd0 && !o_entry_fix),
        "entry fields set without a match")

    // entry fix only for a single mismatching entry
    `ASSERT_ALWAYS(a_entry_fix, !(o_out_valid && o_entry_fix)
        || (o_entry_hits == HITS_ONE && o_entry_sum_stored != o_entry_sum_calc),
        "entry fix without single mismatching entry")

    // image fix flags exactly a checksum mismatch
    `ASSERT_ALWAYS(a_image_fix,
        !o_out_valid || (o_image_fix == (o_image_sum_stored != o_image_sum_calc)),
        "image fix disagrees with checksums")

endmodule

bind rom_image_checksum_fixer_unit ricf_checker u_ricf_checker (.*);

// ===== sim/rom_image_checksum_fixer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_image_checksum_fixer_unit_tb
// Streams ROM images byte by byte into the checksum fixer and compares every
// result against a cycle-free model of the image and PMID entry checksums.
// A short table of hand-made images opens the run. Random images follow,
// most with planted PMID signatures and some with repaired checksums. One
// tidy image with two planted entries closes it. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module rom_image_checksum_fixer_unit_tb;
    import ricf_pkg::*;

    localparam int IMG_BYTES   = IMAGE_BYTES_DEF;
    localparam int ENTRY_LEN   = ENTRY_BYTES_DEF;
    localparam int LAST_START  = IMG_BYTES - ENTRY_LEN - 1;
    localparam int SMALL_BYTES = 1700;
    localparam int TIDY_BYTES  = 64;

    localparam logic [7:0] CH_P = SIG_PMI[23:16];
    localparam logic [7:0] CH_M = SIG_PMI[15:8];
    localparam logic [7:0] CH_I = SIG_PMI[7:0];

    localparam t_result SUM_OF_ZERO = '0;
    localparam t_result SUM_OF_FF   =
        '{HITS_NONE, 15'd0, 8'h00, 8'h00, 1'b0, 8'h00, 8'h01, 1'b1};

    typedef struct {
        int       pos;
        bit [23:0] recent;
        bit [7:0] img_sum;
        bit [1:0] hits;
        int       hit_at;
        bit [7:0] entry_sum;
        bit [7:0] entry_ck;
        bit [7:0] final_b;
    } t_scan_state;

    typedef struct {
        bit [7:0] b;
        bit       lst;
        bit       typed;
        t_result  want;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic [7:0]          i_data_byte = 8'h00;
    logic                i_last = 1'b0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [HITS_W-1:0]   o_entry_hits;
    logic [OFFSET_W-1:0] o_entry_offset;
    logic [7:0]          o_entry_sum_stored;
    logic [7:0]          o_entry_sum_calc;
    logic                o_entry_fix;
    logic [7:0]          o_image_sum_stored;
    logic [7:0]          o_image_sum_calc;
    logic                o_image_fix;

    t_scan_state model = '{default: 0};
    t_result     pending_sums[$];
    t_result     want;
    bit [7:0]    image_bytes[$];
    bit          send_calm = 1'b1;
    bit          recv_calm = 1'b0;
    int          errors = 0;
    int          results_seen = 0;
    int          images_sent = 0;
    int          bytes_sent = 0;

    // short images, a signature at offset zero, two signatures, one short entry
    t_plan_row plan[$] = '{
        '{8'h00, 1'b1, 1'b1, SUM_OF_ZERO},
        '{8'hFF, 1'b1, 1'b1, SUM_OF_FF},
        '{CH_P,  1'b0, 1'b0, '0}, '{CH_M, 1'b0, 1'b0, '0}, '{CH_I, 1'b0, 1'b0, '0},
        '{SIG_D, 1'b0, 1'b0, '0}, '{SIG_D, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{CH_P,  1'b0, 1'b0, '0}, '{CH_M, 1'b0, 1'b0, '0}, '{CH_I, 1'b0, 1'b0, '0},
        '{SIG_D, 1'b0, 1'b0, '0},
        '{CH_P,  1'b0, 1'b0, '0}, '{CH_M, 1'b0, 1'b0, '0}, '{CH_I, 1'b0, 1'b0, '0},
        '{SIG_D, 1'b0, 1'b0, '0}, '{8'h7F, 1'b1, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{CH_P,  1'b0, 1'b0, '0}, '{CH_M, 1'b0, 1'b0, '0}, '{CH_I, 1'b0, 1'b0, '0},
        '{SIG_D, 1'b0, 1'b0, '0}, '{8'h01, 1'b1, 1'b0, '0}
    };

    rom_image_checksum_fixer_unit #(
        .IMAGE_BYTES(IMG_BYTES),
        .ENTRY_BYTES(ENTRY_LEN)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_last             (i_last),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_entry_hits       (o_entry_hits),
        .o_entry_offset     (o_entry_offset),
        .o_entry_sum_stored (o_entry_sum_stored),
        .o_entry_sum_calc   (o_entry_sum_calc),
        .o_entry_fix        (o_entry_fix),
        .o_image_sum_stored (o_image_sum_stored),
        .o_image_sum_calc   (o_image_sum_calc),
        .o_image_fix        (o_image_fix)
    );

    always #6 i_clk = ~i_clk;

    // folds one byte into the image state; returns 1 with the sums on a last beat
    function automatic bit scan_byte(inout t_scan_state s, input bit [7:0] b,
                                     input bit lst, output t_result r);
        int       k;
        bit [7:0] img;
        r = '0;
        if (s.pos < IMG_BYTES) begin
            if (s.pos <= IMG_BYTES - 2) begin
                s.img_sum += b;
            end else begin
                s.final_b = b;
            end
            if (s.hits != HITS_NONE && s.pos >= s.hit_at) begin
                k = s.pos - s.hit_at;
                if (k >= SIG_BYTES && k < ENTRY_LEN - 1) begin
                    s.entry_sum += b;
                end else if (k == ENTRY_LEN - 1) begin
                    s.entry_ck = b;
                end
            end
            // the match start is checked only from offset one on
            if (s.pos >= SIG_BYTES && s.recent == SIG_PMI && b == SIG_D &&
                s.pos - (SIG_BYTES - 1) <= LAST_START) begin
                if (s.hits != HITS_MANY) begin
                    s.hits += HITS_ONE;
                end
                s.hit_at    = s.pos - (SIG_BYTES - 1);
                s.entry_sum = SIG_SUM;
                s.entry_ck  = 8'h00;
            end
            s.recent = {s.recent[15:0], b};
            s.pos++;
        end
        if (!lst) begin
            return 1'b0;
        end
        img = s.img_sum;
        if (s.hits != HITS_NONE) begin
            r.entry_offset     = s.hit_at[OFFSET_W-1:0];
            r.entry_sum_stored = s.entry_ck;
            r.entry_sum_calc   = 8'd0 - s.entry_sum;
        end
        if (s.hits == HITS_ONE) begin
            r.entry_fix = (r.entry_sum_stored != r.entry_sum_calc);
            img = img - r.entry_sum_stored + r.entry_sum_calc;
        end
        r.entry_hits       = s.hits;
        r.image_sum_stored = s.final_b;
        r.image_sum_calc   = 8'd0 - img;
        r.image_fix        = (r.image_sum_stored != r.image_sum_calc);
        s = '{default: 0};
        return 1'b1;
    endfunction

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // signature letters often, so that partial and broken signatures show up
    function automatic bit [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: begin
                return CH_P;
            end
            1: begin
                return CH_M;
            end
            2: begin
                return CH_I;
            end
            3: begin
                return SIG_D;
            end
            4: begin
                return 8'h00;
            end
            5: begin
                return 8'hFF;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, exp_val);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_sums.size() == 0) begin
                report_mismatch("result with nothing pending", o_image_sum_calc, 0);
            end else begin
                want = pending_sums.pop_front();
                if (o_entry_hits !== want.entry_hits)
                    report_mismatch("entry_hits", o_entry_hits, want.entry_hits);
                if (o_entry_offset !== want.entry_offset)
                    report_mismatch("entry_offset", o_entry_offset, want.entry_offset);
                if (o_entry_sum_stored !== want.entry_sum_stored)
                    report_mismatch("entry_sum_stored", o_entry_sum_stored,
                                    want.entry_sum_stored);
                if (o_entry_sum_calc !== want.entry_sum_calc)
                    report_mismatch("entry_sum_calc", o_entry_sum_calc, want.entry_sum_calc);
                if (o_entry_fix !== want.entry_fix)
                    report_mismatch("entry_fix", o_entry_fix, want.entry_fix);
                if (o_image_sum_stored !== want.image_sum_stored)
                    report_mismatch("image_sum_stored", o_image_sum_stored,
                                    want.image_sum_stored);
                if (o_image_sum_calc !== want.image_sum_calc)
                    report_mismatch("image_sum_calc", o_image_sum_calc, want.image_sum_calc);
                if (o_image_fix !== want.image_fix)
                    report_mismatch("image_fix", o_image_fix, want.image_fix);
            end
        end
    end

    // result side: stall for a drawn number of cycles, then take one beat
    initial begin
        forever begin
            repeat (draw_wait(recv_calm)) @(negedge i_clk) i_out_stall <= 1'b1;
            @(negedge i_clk) i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
        end
    end

    task automatic push_byte(input bit [7:0] b, input bit lst, input bit typed,
                             input t_result typed_want);
        t_result r;
        repeat (draw_wait(send_calm)) @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last      <= lst;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
        if (scan_byte(model, b, lst, r)) begin
            pending_sums.push_back(typed ? typed_want : r);
        end
    endtask

    // lowers valid and holds off until every pending result has come back
    task automatic drain_results();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
    endtask

    // random bytes with planted signatures; entry and image sums repaired at times
    task automatic compose_image(input int len, input int sigs, input int pin_at,
                                 input bit tidy);
        int          at;
        int          starts[$];
        bit [7:0]    acc;
        t_scan_state probe;
        t_result     r;
        image_bytes.delete();
        for (int i = 0; i < len; i++) image_bytes.push_back(pick_byte());
        if (pin_at >= 0) begin
            starts.push_back(pin_at);
            starts.push_back(pin_at + SIG_BYTES);
        end
        if (len >= SIG_BYTES) begin
            repeat (sigs) starts.push_back($urandom_range(0, len - SIG_BYTES));
        end
        foreach (starts[j]) begin
            at = starts[j];
            image_bytes[at]     = CH_P;
            image_bytes[at + 1] = CH_M;
            image_bytes[at + 2] = CH_I;
            image_bytes[at + 3] = SIG_D;
        end
        foreach (starts[j]) begin
            at = starts[j];
            if (at + ENTRY_LEN - 1 < len && (tidy || $urandom_range(0, 1) == 1)) begin
                acc = 8'h00;
                for (int k = 0; k < ENTRY_LEN - 1; k++) acc += image_bytes[at + k];
                image_bytes[at + ENTRY_LEN - 1] = 8'd0 - acc;
            end
        end
        // byte zero never takes part in a counted entry, so it balances the image
        if (tidy || $urandom_range(0, 2) == 0) begin
            probe = '{default: 0};
            foreach (image_bytes[i]) begin
                void'(scan_byte(probe, image_bytes[i], i == image_bytes.size() - 1, r));
            end
            image_bytes[0] += r.image_sum_calc - r.image_sum_stored;
        end
    endtask

    task automatic play_image();
        foreach (image_bytes[i]) begin
            push_byte(image_bytes[i], i == image_bytes.size() - 1, 1'b0, '0);
        end
        images_sent++;
    endtask

    initial begin
        int len;
        int sigs;
        int small_fed;
        small_fed = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // back-to-back last beats in the table
        foreach (plan[i]) push_byte(plan[i].b, plan[i].lst, plan[i].typed, plan[i].want);
        images_sent += 5;
        drain_results();

        while (small_fed < SMALL_BYTES) begin
            send_calm = ($urandom_range(0, 4) == 0);
            recv_calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    len = $urandom_range(1, 4);
                end
                7, 8: begin
                    len = $urandom_range(20, 64);
                end
                9: begin
                    len = $urandom_range(65, 200);
                end
                default: begin
                    len = $urandom_range(5, 40);
                end
            endcase
            sigs = $urandom_range(0, 5);
            if (sigs > 3) begin
                sigs = 1;
            end
            compose_image(len, sigs, -1, 1'b0);
            play_image();
            small_fed += len;
            if ($urandom_range(0, 5) == 0) begin
                drain_results();
            end
        end

        // tidy image with two planted entries, the first at offset one
        send_calm = 1'b1;
        recv_calm = 1'b0;
        compose_image(TIDY_BYTES, 0, 1, 1'b1);
        play_image();
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("ran %0d images, %0d beats; %0d results compared", images_sent,
                 bytes_sent, results_seen);
        $display("mix: short images, none to several PMID entries, repaired sums");
        if (errors == 0) begin
            $display("rom_image_checksum_fixer_unit_tb OK");
        end else begin
            $display("rom_image_checksum_fixer_unit_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #36_000_000;
        $display("timeout with %0d results pending", pending_sums.size());
        $display("rom_image_checksum_fixer_unit_tb NOT OK");
        $finish;
    end

endmodule
